@@ rtl/arc_pkg.sv @@
package arc_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int PENDING_ENTRIES_DEF = 8;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int AGE_W      = 16;
  localparam int HANDLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_USER_W = 2;

  typedef logic [IP_W-1:0]     ip_t;
  typedef logic [MAC_W-1:0]    mac_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    FUNC_ARP_RX   = 2'd0,
    FUNC_PKT_TX   = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_ANNOUNCE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_SEND    = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP     = 2'd0,
    CFG_OWN_MAC    = 2'd1,
    CFG_ENTRY_LIFE = 2'd2,
    CFG_PEND_LIFE  = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'h0001;
  localparam mac_t        BCAST_MAC      = {MAC_W{1'b1}};
  localparam age_t        AGE_MAX        = {AGE_W{1'b1}};
  localparam age_t        ENTRY_LIFE_RST = 16'd60;
  localparam age_t        PEND_LIFE_RST  = 16'd1;

  typedef struct packed {
    logic [6:0]  pad;
    handle_t     packet_handle;
    ip_t         next_hop_ip;
    ip_t         asked_ip;
    mac_t        peer_mac;
    ip_t         peer_ip;
    logic [15:0] arp_opcode;
    logic [7:0]  proto_addr_len;
    logic [7:0]  hw_addr_len;
    logic [15:0] proto_type;
    logic [15:0] hw_type;
    logic        too_short;
  } in_item_t;

  typedef struct packed {
    handle_t packet_handle_out;
    mac_t    arp_target_mac;
    ip_t     arp_target_ip;
    mac_t    dest_mac;
  } out_item_t;

  typedef struct packed {
    logic learn;
    logic tick;
  } cache_cmd_t;

  typedef struct packed {
    logic hold;
    logic release_hit;
    logic tick;
  } pend_cmd_t;

  function automatic age_t age_step(age_t a);
    return (a == AGE_MAX) ? a : age_t'(a + age_t'(1));
  endfunction

endpackage

@@ rtl/arc_oldest.sv @@
module arc_oldest #(
  parameter int N = 16,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]   valid,
  input  arc_pkg::age_t  age [N],
  output logic [IW-1:0]  slot
);
  import arc_pkg::*;

  localparam int P = 1 << IW;

  logic          lv_ok  [IW+1][P];
  age_t          lv_age [IW+1][P];
  logic [IW-1:0] lv_idx [IW+1][P];
  logic          free_any;
  logic [IW-1:0] free_idx;

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign lv_ok[0][i]  = 1'b1;
      assign lv_age[0][i] = age[i];
    end else begin : g_pad
      assign lv_ok[0][i]  = 1'b0;
      assign lv_age[0][i] = '0;
    end
    assign lv_idx[0][i] = IW'(i);
  end

  // keep the left side on ties: it holds the lower index
  for (genvar l = 0; l < IW; l++) begin : g_lvl
    for (genvar j = 0; j < (P >> (l + 1)); j++) begin : g_node
      logic pick_b;
      assign pick_b = lv_ok[l][2*j+1] &&
                      (!lv_ok[l][2*j] || (lv_age[l][2*j+1] > lv_age[l][2*j]));
      assign lv_ok[l+1][j]  = lv_ok[l][2*j] || lv_ok[l][2*j+1];
      assign lv_age[l+1][j] = pick_b ? lv_age[l][2*j+1] : lv_age[l][2*j];
      assign lv_idx[l+1][j] = pick_b ? lv_idx[l][2*j+1] : lv_idx[l][2*j];
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign slot = free_any ? free_idx : lv_idx[IW][0];

endmodule

@@ rtl/arc_cache_table.sv @@
module arc_cache_table #(
  parameter int N = 16,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arc_pkg::cache_cmd_t cmd,
  input  arc_pkg::ip_t        lookup_ip,
  input  arc_pkg::mac_t       learn_mac,
  input  arc_pkg::age_t       lifetime,
  output logic                hit,
  output arc_pkg::mac_t       hit_mac
);
  import arc_pkg::*;

  logic [N-1:0]  valid_r, valid_nxt;
  ip_t           ip_r  [N];
  mac_t          mac_r [N];
  age_t          age_r [N];
  logic [N-1:0]  match;
  logic [IW-1:0] hit_idx, victim, slot;

  always_comb begin
    hit_idx = '0;
    hit_mac = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (ip_r[i] == lookup_ip);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
        hit_mac = mac_r[i];
      end
    end
  end

  assign hit = |match;

  arc_oldest #(.N(N)) u_oldest (
    .valid (valid_r),
    .age   (age_r),
    .slot  (victim)
  );

  assign slot = hit ? hit_idx : victim;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_nxt[i] = valid_r[i];
      if (cmd.learn && (slot == IW'(i))) begin
        valid_nxt[i] = 1'b1;
      end else if (cmd.tick && valid_r[i] && (age_step(age_r[i]) > lifetime)) begin
        valid_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.learn && (slot == IW'(i))) begin
        ip_r[i]  <= lookup_ip;
        mac_r[i] <= learn_mac;
        age_r[i] <= '0;
      end else if (cmd.tick && valid_r[i]) begin
        age_r[i] <= age_step(age_r[i]);
      end
    end
  end

endmodule

@@ rtl/arc_pending_table.sv @@
module arc_pending_table #(
  parameter int N = 8,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  arc_pkg::pend_cmd_t cmd,
  input  arc_pkg::ip_t       lookup_ip,
  input  arc_pkg::handle_t   hold_handle,
  input  arc_pkg::age_t      lifetime,
  output logic               hit,
  output arc_pkg::handle_t   hit_handle
);
  import arc_pkg::*;

  logic [N-1:0]  valid_r, valid_nxt;
  ip_t           ip_r     [N];
  handle_t       handle_r [N];
  age_t          age_r    [N];
  logic [N-1:0]  match;
  logic [IW-1:0] hit_idx, victim;

  always_comb begin
    hit_idx    = '0;
    hit_handle = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (ip_r[i] == lookup_ip);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx    = IW'(i);
        hit_handle = handle_r[i];
      end
    end
  end

  assign hit = |match;

  arc_oldest #(.N(N)) u_oldest (
    .valid (valid_r),
    .age   (age_r),
    .slot  (victim)
  );

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_nxt[i] = valid_r[i];
      if (cmd.hold && (victim == IW'(i))) begin
        valid_nxt[i] = 1'b1;
      end else if (cmd.release_hit && (hit_idx == IW'(i))) begin
        valid_nxt[i] = 1'b0;
      end else if (cmd.tick && valid_r[i] && (age_step(age_r[i]) > lifetime)) begin
        valid_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.hold && (victim == IW'(i))) begin
        ip_r[i]     <= lookup_ip;
        handle_r[i] <= hold_handle;
        age_r[i]    <= '0;
      end else if (cmd.tick && valid_r[i]) begin
        age_r[i] <= age_step(age_r[i]);
      end
    end
  end

endmodule

@@ rtl/arp_resolver_cache_unit.sv @@
// Channel  Direction  Handshake              Payload
// in_      input      in_tvalid / in_tready  tuser: func; tdata: ARP and packet fields
// out_     output     out_tvalid / out_tready tuser: action; tdata: MACs, target IP, handle
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while no result is held: input register, table lookup and update,
// result register. Table writes land with the result load, so the following item
// already sees them.
// rst_n (synchronous, low) clears both tables' valid bits and loads register defaults.
// A held result stalls the input register; in_tready stays high while it can drain.
// cfg_ready is always high.
module arp_resolver_cache_unit #(
  parameter int CACHE_ENTRIES   = arc_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_ENTRIES = arc_pkg::PENDING_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // too_short, hw_type, proto_type, hw_addr_len, proto_addr_len, arp_opcode,
  // peer_ip, peer_mac, asked_ip, next_hop_ip, packet_handle, zero pad
  input  logic [arc_pkg::IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [arc_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // dest_mac, arp_target_ip, arp_target_mac, packet_handle_out
  output logic [arc_pkg::OUT_DATA_W-1:0] out_tdata,
  // action
  output logic [arc_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arc_pkg::*;

  logic       st_valid_r, st_valid_nxt;
  func_t      st_func_r;
  in_item_t   st_item_r;
  logic       out_valid_r, out_valid_nxt;
  action_t    out_action_r;
  out_item_t  out_item_r;
  ip_t        own_ip_r;
  mac_t       own_mac_r;
  age_t       entry_life_r;
  age_t       pend_life_r;

  logic       in_fire, advance, hdr_ok, arp_ok;
  ip_t        lookup_ip;
  cache_cmd_t cache_cmd;
  pend_cmd_t  pend_cmd;
  logic       cache_hit, pend_hit;
  mac_t       cache_mac;
  handle_t    pend_handle;
  logic       res_valid;
  action_t    res_action;
  out_item_t  res_item;

  assign cfg_ready = 1'b1;
  assign advance   = st_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !st_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_fire) begin
      st_valid_nxt = 1'b1;
    end else if (advance) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_func_r <= func_t'(in_tuser);
      st_item_r <= in_tdata;
    end
  end

  assign hdr_ok = !st_item_r.too_short && (st_item_r.hw_type == HW_TYPE_ETH) &&
                  (st_item_r.proto_type == PROTO_IPV4) &&
                  (st_item_r.hw_addr_len == HW_LEN_ETH) &&
                  (st_item_r.proto_addr_len == PROTO_LEN_IPV4);
  assign arp_ok = advance && (st_func_r == FUNC_ARP_RX) && hdr_ok;

  assign lookup_ip = (st_func_r == FUNC_ARP_RX) ? st_item_r.peer_ip
                                                : st_item_r.next_hop_ip;

  assign cache_cmd.learn = arp_ok;
  assign cache_cmd.tick  = advance && (st_func_r == FUNC_TICK);

  assign pend_cmd.release_hit = arp_ok && pend_hit;
  assign pend_cmd.hold        = advance && (st_func_r == FUNC_PKT_TX) && !cache_hit &&
                                !pend_hit;
  assign pend_cmd.tick        = advance && (st_func_r == FUNC_TICK);

  arc_cache_table #(.N(CACHE_ENTRIES)) u_cache (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cache_cmd),
    .lookup_ip (lookup_ip),
    .learn_mac (st_item_r.peer_mac),
    .lifetime  (entry_life_r),
    .hit       (cache_hit),
    .hit_mac   (cache_mac)
  );

  arc_pending_table #(.N(PENDING_ENTRIES)) u_pending (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (pend_cmd),
    .lookup_ip   (lookup_ip),
    .hold_handle (st_item_r.packet_handle),
    .lifetime    (pend_life_r),
    .hit         (pend_hit),
    .hit_handle  (pend_handle)
  );

  always_comb begin
    res_valid  = 1'b0;
    res_action = ACT_REQUEST;
    res_item   = '0;
    unique case (st_func_r)
      FUNC_ARP_RX: begin
        if (hdr_ok) begin
          if (pend_hit) begin
            res_valid                  = 1'b1;
            res_action                 = ACT_SEND;
            res_item.dest_mac          = st_item_r.peer_mac;
            res_item.packet_handle_out = pend_handle;
          end else if ((st_item_r.arp_opcode == OP_REQUEST) &&
                       (st_item_r.asked_ip == own_ip_r)) begin
            res_valid               = 1'b1;
            res_action              = ACT_REPLY;
            res_item.dest_mac       = st_item_r.peer_mac;
            res_item.arp_target_ip  = st_item_r.peer_ip;
            res_item.arp_target_mac = st_item_r.peer_mac;
          end
        end
      end
      FUNC_PKT_TX: begin
        if (cache_hit) begin
          res_valid                  = 1'b1;
          res_action                 = ACT_SEND;
          res_item.dest_mac          = cache_mac;
          res_item.packet_handle_out = st_item_r.packet_handle;
        end else if (!pend_hit) begin
          res_valid              = 1'b1;
          res_action             = ACT_REQUEST;
          res_item.dest_mac      = BCAST_MAC;
          res_item.arp_target_ip = st_item_r.next_hop_ip;
        end
      end
      FUNC_TICK: begin
        res_valid = 1'b0;
      end
      FUNC_ANNOUNCE: begin
        res_valid              = 1'b1;
        res_action             = ACT_REQUEST;
        res_item.dest_mac      = BCAST_MAC;
        res_item.arp_target_ip = own_ip_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_action_r <= res_action;
      out_item_r   <= res_item;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r     <= '0;
      own_mac_r    <= '0;
      entry_life_r <= ENTRY_LIFE_RST;
      pend_life_r  <= PEND_LIFE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OWN_IP:     own_ip_r     <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC:    own_mac_r    <= cfg_data[MAC_W-1:0];
        CFG_ENTRY_LIFE: entry_life_r <= cfg_data[AGE_W-1:0];
        CFG_PEND_LIFE:  pend_life_r  <= cfg_data[AGE_W-1:0];
      endcase
    end
  end

endmodule

@@ rtl/arc_checker.sv @@
module arc_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [arc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [arc_pkg::OUT_USER_W-1:0] out_tuser
);
  import arc_pkg::*;

  out_item_t ov;
  assign ov = out_tdata;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  a_request_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ACT_REQUEST)) |->
      ((ov.dest_mac == BCAST_MAC) && (ov.arp_target_mac == '0) &&
       (ov.packet_handle_out == '0)))
    else $error("malformed request item");

  a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ACT_REPLY)) |->
      ((ov.dest_mac == ov.arp_target_mac) && (ov.packet_handle_out == '0)))
    else $error("malformed reply item");

  a_send_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ACT_SEND)) |->
      ((ov.arp_target_ip == '0) && (ov.arp_target_mac == '0)))
    else $error("malformed send item");

endmodule

bind arp_resolver_cache_unit arc_props u_arc_props (.*);
